FILE: hw/rtl/swms_pkg.sv
package swms_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W       = 5;
    localparam int DATA_W      = 32;
    localparam int SUM_W       = 36;
    localparam int SQ_W        = 64;
    localparam int SSQ_W       = 67;
    localparam int WIDE_W      = 72;
    localparam int DIVR_W      = 9;
    localparam int STEP_W      = 7;
    localparam int DIV_STEPS   = WIDE_W;
    localparam int SQRT_STEPS  = 32;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 5'd10;
    localparam logic [CNT_W-1:0] WINDOW_FULL  = 5'd16;

    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_SAMPLE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MULN,
        ST_MULS,
        ST_DIVM,
        ST_DIVV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/swms_ram.sv
module swms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/sliding_window_mean_stddev_unit.sv
// Moving-window mean and population standard deviation over the most recent
// window_size signed 32-bit samples (window_size 0 acts as 1, above 16 as 16).
// A transfer with s_tuser = 0 restarts the window (no result); with s_tuser = 1
// it stores s_tdata and, later, delivers one result: truncated mean, rounded-down
// population deviation and the number of samples covered. One item is in work
// at a time; a sample item passes through a walk over the filled window
// entries through the one read port of the sample memory, a shift-add
// multiplier, a bit-serial divider run twice and a 32-step square root. A
// restart item leaves the block idle, ready for the next item. The result
// sits in an output register, so a new item is taken while the last result
// still waits on m_tready. Write window_size only while the block is idle.
module sliding_window_mean_stddev_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        window_size_we,
    input  logic [4:0]  window_size_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic        s_tuser,   // [0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] mean_value, [63:32] deviation,
                                   // [68:64] filled, [71:69] zero
);

    swms_pkg::state_t state_reg, state_next;

    // control
    logic [swms_pkg::CNT_W-1:0]  window_size_reg;
    logic [swms_pkg::CNT_W-1:0]  wp_reg;
    logic [swms_pkg::CNT_W-1:0]  fill_reg;
    logic                        out_valid_reg;
    logic                        rd_vld_reg;
    logic                        sq_vld_reg;

    // datapath
    logic [swms_pkg::CNT_W-1:0]  rd_idx_reg;
    logic [swms_pkg::CNT_W-1:0]  cnt_reg;
    logic [swms_pkg::CNT_W-1:0]  n_reg;
    logic signed [swms_pkg::SUM_W-1:0] sum_reg;
    logic [swms_pkg::SQ_W-1:0]   sq_reg;
    logic [swms_pkg::SSQ_W-1:0]  ssq_reg;
    logic [swms_pkg::WIDE_W-1:0] mc_reg;
    logic [swms_pkg::SUM_W-1:0]  mp_reg;
    logic [swms_pkg::WIDE_W-1:0] acc_reg;
    logic [swms_pkg::WIDE_W-1:0] tnum_reg;
    logic [swms_pkg::WIDE_W-1:0] dq_reg;
    logic [swms_pkg::DIVR_W-1:0] rem_reg;
    logic [swms_pkg::DIVR_W-1:0] d_reg;
    logic [swms_pkg::STEP_W-1:0] step_reg;
    logic [swms_pkg::SQ_W-1:0]   v_reg;
    logic [swms_pkg::SQ_W-1:0]   res_reg;
    logic [swms_pkg::SQ_W-1:0]   bit_reg;
    logic [swms_pkg::DATA_W-1:0] mean_reg;
    logic [swms_pkg::DATA_W-1:0] dev_reg;
    logic [71:0]                 m_tdata_reg;

    logic                        accept;
    logic                        is_sample;
    logic [swms_pkg::CNT_W-1:0]  n_eff;
    logic [swms_pkg::CNT_W:0]    fill_inc;
    logic [swms_pkg::CNT_W-1:0]  cnt_new;
    logic                        issue;
    logic                        walk_done;
    logic                        out_load;
    logic [swms_pkg::DATA_W-1:0] rdata;
    logic signed [swms_pkg::SQ_W-1:0] prod;
    logic [swms_pkg::SUM_W-1:0]  abs_sum;
    logic [swms_pkg::DIVR_W:0]   div_r2;
    logic                        div_ge;
    logic [swms_pkg::DIVR_W-1:0] rem_step;
    logic [swms_pkg::WIDE_W-1:0] dq_step;
    logic [swms_pkg::SUM_W-1:0]  q_neg;
    logic [swms_pkg::SQ_W-1:0]   sq_t;
    logic                        sq_ge;
    logic [swms_pkg::SQ_W-1:0]   v_step;
    logic [swms_pkg::SQ_W-1:0]   res_step;
    logic [9:0]                  cnt_sq;
    logic                        div_last;

    // ---------------------------------------------------------------
    // Handshake and per-item setup
    // ---------------------------------------------------------------
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (s_tuser == swms_pkg::MODE_SAMPLE);

    // Clamp the window size into 1..WINDOW_MAX
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            n_eff = swms_pkg::CNT_W'(1);
        end
        else if (window_size_reg > swms_pkg::WINDOW_FULL)
        begin
            n_eff = swms_pkg::WINDOW_FULL;
        end
        else
        begin
            n_eff = window_size_reg;
        end
    end

    assign fill_inc = {1'b0, fill_reg} + (swms_pkg::CNT_W+1)'(1);
    assign cnt_new  = (fill_inc > {1'b0, n_eff}) ? n_eff : fill_inc[swms_pkg::CNT_W-1:0];

    // ---------------------------------------------------------------
    // Sample memory: write on a sample accept, walk entries 0..cnt-1 for reads
    // ---------------------------------------------------------------
    assign issue     = (state_reg == swms_pkg::ST_WALK) && (rd_idx_reg < cnt_reg);
    assign walk_done = (state_reg == swms_pkg::ST_WALK) && (rd_idx_reg == cnt_reg)
                       && !rd_vld_reg && !sq_vld_reg;

    swms_ram #(
        .WIDTH (swms_pkg::DATA_W),
        .DEPTH (swms_pkg::WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (accept && is_sample),
        .waddr (wp_reg[swms_pkg::ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (rd_idx_reg[swms_pkg::ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign prod    = $signed(rdata) * $signed(rdata);
    assign abs_sum = sum_reg[swms_pkg::SUM_W-1] ? swms_pkg::SUM_W'(-sum_reg)
                                                : swms_pkg::SUM_W'(sum_reg);

    // ---------------------------------------------------------------
    // Restoring divider step (one quotient bit a cycle)
    // ---------------------------------------------------------------
    assign div_r2   = {rem_reg, dq_reg[swms_pkg::WIDE_W-1]};
    assign div_ge   = (div_r2 >= {1'b0, d_reg});
    assign rem_step = div_ge ? swms_pkg::DIVR_W'(div_r2 - {1'b0, d_reg})
                             : div_r2[swms_pkg::DIVR_W-1:0];
    assign dq_step  = {dq_reg[swms_pkg::WIDE_W-2:0], div_ge};
    assign q_neg    = ~dq_step[swms_pkg::SUM_W-1:0] + swms_pkg::SUM_W'(1);
    assign cnt_sq   = cnt_reg * cnt_reg;
    assign div_last = (step_reg == swms_pkg::STEP_W'(swms_pkg::DIV_STEPS - 1));

    // ---------------------------------------------------------------
    // Square root step (two radicand bits a cycle)
    // ---------------------------------------------------------------
    assign sq_t     = res_reg + bit_reg;
    assign sq_ge    = (v_reg >= sq_t);
    assign v_step   = sq_ge ? (v_reg - sq_t) : v_reg;
    assign res_step = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    state_next = swms_pkg::ST_WALK;
                end
            end
            swms_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = swms_pkg::ST_MULN;
                end
            end
            swms_pkg::ST_MULN:
            begin
                if (mp_reg == '0)
                begin
                    state_next = swms_pkg::ST_MULS;
                end
            end
            swms_pkg::ST_MULS:
            begin
                if (mp_reg == '0)
                begin
                    state_next = swms_pkg::ST_DIVM;
                end
            end
            swms_pkg::ST_DIVM:
            begin
                if (div_last)
                begin
                    state_next = swms_pkg::ST_DIVV;
                end
            end
            swms_pkg::ST_DIVV:
            begin
                if (div_last)
                begin
                    state_next = swms_pkg::ST_SQRT;
                end
            end
            swms_pkg::ST_SQRT:
            begin
                if (step_reg == swms_pkg::STEP_W'(swms_pkg::SQRT_STEPS - 1))
                begin
                    state_next = swms_pkg::ST_DONE;
                end
            end
            swms_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = swms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swms_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        s_tready = (state_reg == swms_pkg::ST_IDLE);
        out_load = (state_reg == swms_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= swms_pkg::ST_IDLE;
            window_size_reg <= swms_pkg::WINDOW_RESET;
            wp_reg          <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
            rd_vld_reg      <= 1'b0;
            sq_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            sq_vld_reg <= rd_vld_reg;

            if (window_size_we)
            begin
                window_size_reg <= window_size_wdata;
            end

            // Advance the write position now, wrap it over the busy cycles
            if (accept)
            begin
                if (is_sample)
                begin
                    wp_reg   <= {1'b0, wp_reg[swms_pkg::ADDR_W-1:0]} + swms_pkg::CNT_W'(1);
                    fill_reg <= cnt_new;
                end
                else
                begin
                    wp_reg   <= '0;
                    fill_reg <= '0;
                end
            end
            else if ((state_reg != swms_pkg::ST_IDLE) && (wp_reg >= n_reg))
            begin
                wp_reg <= wp_reg - n_reg;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    rd_idx_reg <= '0;
                    cnt_reg    <= cnt_new;
                    n_reg      <= n_eff;
                    sum_reg    <= '0;
                    ssq_reg    <= '0;
                end
            end
            swms_pkg::ST_WALK:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + swms_pkg::CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    sum_reg <= sum_reg + swms_pkg::SUM_W'($signed(rdata));
                end
                sq_reg <= swms_pkg::SQ_W'(prod);
                if (sq_vld_reg)
                begin
                    ssq_reg <= ssq_reg + swms_pkg::SSQ_W'(sq_reg);
                end
                if (walk_done)
                begin
                    mc_reg  <= swms_pkg::WIDE_W'(ssq_reg);
                    mp_reg  <= swms_pkg::SUM_W'(cnt_reg);
                    acc_reg <= '0;
                end
            end
            swms_pkg::ST_MULN,
            swms_pkg::ST_MULS:
            begin
                if (mp_reg == '0)
                begin
                    if (state_reg == swms_pkg::ST_MULN)
                    begin
                        // n * sum(x^2) done; start (sum x)^2
                        tnum_reg <= acc_reg;
                        mc_reg   <= swms_pkg::WIDE_W'(abs_sum);
                        mp_reg   <= abs_sum;
                        acc_reg  <= '0;
                    end
                    else
                    begin
                        // S = n*sum(x^2) - (sum x)^2; divide |sum| by n first
                        tnum_reg <= tnum_reg - acc_reg;
                        dq_reg   <= swms_pkg::WIDE_W'(abs_sum);
                        rem_reg  <= '0;
                        d_reg    <= swms_pkg::DIVR_W'(cnt_reg);
                        step_reg <= '0;
                    end
                end
                else
                begin
                    if (mp_reg[0])
                    begin
                        acc_reg <= acc_reg + mc_reg;
                    end
                    mc_reg <= mc_reg << 1;
                    mp_reg <= mp_reg >> 1;
                end
            end
            swms_pkg::ST_DIVM:
            begin
                rem_reg  <= rem_step;
                dq_reg   <= dq_step;
                step_reg <= step_reg + swms_pkg::STEP_W'(1);
                if (div_last)
                begin
                    mean_reg <= sum_reg[swms_pkg::SUM_W-1] ? q_neg[swms_pkg::DATA_W-1:0]
                                                           : dq_step[swms_pkg::DATA_W-1:0];
                    dq_reg   <= tnum_reg;
                    rem_reg  <= '0;
                    d_reg    <= cnt_sq[swms_pkg::DIVR_W-1:0];
                    step_reg <= '0;
                end
            end
            swms_pkg::ST_DIVV:
            begin
                rem_reg  <= rem_step;
                dq_reg   <= dq_step;
                step_reg <= step_reg + swms_pkg::STEP_W'(1);
                if (div_last)
                begin
                    v_reg    <= dq_step[swms_pkg::SQ_W-1:0];
                    res_reg  <= '0;
                    bit_reg  <= swms_pkg::SQ_W'(1) << (swms_pkg::SQ_W - 2);
                    step_reg <= '0;
                end
            end
            swms_pkg::ST_SQRT:
            begin
                v_reg    <= v_step;
                res_reg  <= res_step;
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg + swms_pkg::STEP_W'(1);
                dev_reg  <= res_step[swms_pkg::DATA_W-1:0];
            end
            swms_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    m_tdata_reg <= {3'b000, cnt_reg, dev_reg, mean_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: bench/sliding_window_mean_stddev_unit_tb.sv
module sliding_window_mean_stddev_unit_tb;

    typedef struct {
        logic        mode;
        logic [31:0] sample;
    } reading_t;

    typedef struct {
        logic [31:0] mean_value;
        logic [31:0] deviation;
        logic [4:0]  filled;
    } stats_t;

    logic        clk;
    logic        rst_n;
    logic        window_size_we;
    logic [4:0]  window_size_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] sample
    logic        s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [31:0] mean_value, [63:32] deviation, [68:64] filled

    sliding_window_mean_stddev_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_we    (window_size_we),
        .window_size_wdata (window_size_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

    // Predictor state, a private copy of what the block holds
    logic [31:0] win_mem [swms_pkg::WINDOW_MAX];
    int unsigned wr_pos;
    int unsigned fill_cnt;
    logic [4:0]  win_size_reg;

    reading_t pending_readings[$];
    stats_t   expected_stats[$];

    int errors;
    int sent_items;
    int sent_samples;
    int got_results;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int quiet_cycles;
    bit watchdog_tripped;

    localparam int QUIET_LIMIT = 40000;

    always #4 clk = ~clk;

    // Rounded-down square root of a 64-bit value, bit by bit
    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[31:0];
    endfunction

    // Apply one accepted reading to the predictor; push the stats it yields
    task automatic predict_stats(reading_t r);
        int unsigned n;
        int unsigned p;
        longint signed total;
        longint signed diff;
        logic [127:0] spread;
        logic [127:0] var_q;
        stats_t s;
        n = (win_size_reg == 0) ? 1 : (win_size_reg > swms_pkg::WINDOW_MAX ?
                                       swms_pkg::WINDOW_MAX : win_size_reg);
        if (r.mode == swms_pkg::MODE_RESTART)
        begin
            wr_pos = 0;
            fill_cnt = 0;
            return;
        end
        p = (wr_pos < swms_pkg::WINDOW_MAX) ? wr_pos : 0;
        win_mem[p] = r.sample;
        wr_pos = (p + 1) % n;
        fill_cnt = (fill_cnt + 1 > n) ? n : fill_cnt + 1;
        total = 0;
        for (int a = 0; a < fill_cnt; a++)
            total += longint'(signed'(win_mem[a]));
        // pairwise form keeps the spread exact: n*sum(x^2) - (sum x)^2
        spread = 0;
        for (int a = 0; a < fill_cnt; a++)
            for (int b = a + 1; b < fill_cnt; b++)
            begin
                diff = longint'(signed'(win_mem[a])) - longint'(signed'(win_mem[b]));
                if (diff < 0)
                    diff = -diff;
                spread += 128'(diff) * 128'(diff);
            end
        var_q = spread / 128'(fill_cnt * fill_cnt);
        s.mean_value = 32'(total / longint'(fill_cnt));
        s.deviation  = floor_sqrt(var_q[63:0]);
        s.filled     = 5'(fill_cnt);
        expected_stats.push_back(s);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", got_results, what, got, want);
        errors++;
    endtask

    // Driver: hold the item until it transfers, then advance to the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= swms_pkg::MODE_RESTART;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reading_t r;
                r.mode = s_tuser;
                r.sample = s_tdata;
                predict_stats(r);
                sent_items++;
                if (s_tuser == swms_pkg::MODE_SAMPLE)
                    sent_samples++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    reading_t r;
                    r = pending_readings.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= r.sample;
                    s_tuser  <= r.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare every transferred result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                stats_t e;
                if (expected_stats.size() == 0)
                begin
                    $display("unexpected result %h", m_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_stats.pop_front();
                    if (m_tdata[31:0] !== e.mean_value)
                        report_mismatch("mean_value", m_tdata[31:0], e.mean_value);
                    if (m_tdata[63:32] !== e.deviation)
                        report_mismatch("deviation", m_tdata[63:32], e.deviation);
                    if (m_tdata[68:64] !== e.filled)
                        report_mismatch("filled", {27'd0, m_tdata[68:64]}, {27'd0, e.filled});
                end
                got_results++;
            end
            // a long hold-off lets the output register fill and stall input
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles in which nothing transfers
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
            watchdog_tripped <= 1'b1;
    end

    initial
    begin
        @(posedge watchdog_tripped);
        $display("watchdog expired with %0d results outstanding", expected_stats.size());
        $display("sliding_window_mean_stddev_unit_tb NOT OK");
        $finish;
    end

    function automatic logic [31:0] random_sample();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_reading(logic mode, logic [31:0] sample);
        reading_t r;
        r.mode = mode;
        r.sample = sample;
        pending_readings.push_back(r);
    endtask

    // Wait until every queued reading has transferred and every result has come
    task automatic drain();
        while (pending_readings.size() > 0 || s_tvalid || expected_stats.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_window_size(logic [4:0] v);
        @(posedge clk);
        window_size_we    <= 1'b1;
        window_size_wdata <= v;
        @(posedge clk);
        window_size_we    <= 1'b0;
        win_size_reg = v;
    endtask

    // Queue count readings, mostly samples with random values and about one
    // in 40 a restart
    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(39) == 0)
                queue_reading(swms_pkg::MODE_RESTART, $urandom());
            else
                queue_reading(swms_pkg::MODE_SAMPLE, random_sample());
        end
    endtask

    initial
    begin
        logic [4:0] sizes [6];
        sizes = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd7, 5'd16};
        clk = 0;
        rst_n = 0;
        window_size_we = 0;
        window_size_wdata = '0;
        errors = 0;
        sent_items = 0;
        sent_samples = 0;
        got_results = 0;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        watchdog_tripped = 0;
        wr_pos = 0;
        fill_cnt = 0;
        win_size_reg = swms_pkg::WINDOW_RESET;
        for (int i = 0; i < swms_pkg::WINDOW_MAX; i++)
            win_mem[i] = '0;
        send_idle_pct = 17;
        recv_idle_pct = 65;
        repeat (12) @(posedge clk);
        rst_n = 1;

        // Directed: reset window of 10, extremes, restart, shrink while full
        queue_reading(swms_pkg::MODE_RESTART, 32'hFFFF_FFFF);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h7FFF_FFFF);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h8000_0000);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h7FFF_FFFF);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h8000_0000);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h0000_0000);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'hFFFF_FFFD);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h0000_0005);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h8000_0000);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h8000_0000);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h7FFF_FFFF);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h1234_5678);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'hFFFF_FFF9);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h0000_0002);
        // hold the receiver off so the output register fills and input stalls
        hold_off_cycles = 3000;
        drain();
        // shrink while the window is full
        write_window_size(5'd3);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h0000_0010);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h8000_0001);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'h7FFF_FFFE);
        queue_reading(swms_pkg::MODE_SAMPLE, 32'hAAAA_5555);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 17;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window_size(sizes[ph]);
            // restart so a grown window never reads a slot not yet written
            queue_reading(swms_pkg::MODE_RESTART, $urandom());
            random_phase(150);
            drain();
        end

        $display("covered %0d items (%0d samples), %0d results checked, window sizes 0..31",
                 sent_items, sent_samples, got_results);
        if (errors == 0)
            $display("sliding_window_mean_stddev_unit_tb OK");
        else
            $display("sliding_window_mean_stddev_unit_tb NOT OK");
        $finish;
    end
endmodule
